// ----- src/irnm_pkg.sv -----
`timescale 1ns / 1ps

package irnm_pkg;

  // Source image geometry and storage.
  localparam int MAX_DIM     = 64;
  localparam int DIM_BITS    = $clog2(MAX_DIM);
  localparam int ADDR_BITS   = 2 * DIM_BITS;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

  // Field widths.
  localparam int POS_BITS     = 7;
  localparam int PIXEL_BITS   = 32;
  localparam int MASK_BITS    = 8;
  localparam int TRIG_BITS    = 16;
  localparam int SIZE_BITS    = 7;
  localparam int DIM_OUT_BITS = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Fixed-point arithmetic.
  localparam int FRAC_BITS = 14;
  localparam int PROD_BITS = SIZE_BITS + TRIG_BITS;
  localparam int NDIM_BITS = 9;
  localparam int OFF_BITS  = 25;
  localparam int MUL_BITS  = OFF_BITS + TRIG_BITS;
  localparam int SUM_BITS  = MUL_BITS + 1;
  localparam int MAP_BITS  = SUM_BITS - 2 * FRAC_BITS;
  localparam logic [SUM_BITS-1:0] TRUNC_BIAS =
    (SUM_BITS'(1) << (2 * FRAC_BITS)) - SUM_BITS'(1);

  localparam logic [DIM_OUT_BITS-1:0] DIM_OUT_MAX     = 8'd255;
  localparam logic [MASK_BITS-1:0]    BACKGROUND_MASK = 8'hFF;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SINE   = 3'd0,
    CFG_COSINE = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_MASK   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] sine;
    logic signed [TRIG_BITS-1:0] cosine;
    logic [SIZE_BITS-1:0]        width;
    logic [SIZE_BITS-1:0]        height;
    logic                        mask_present;
  } cfg_t;

  typedef struct packed {
    req_t                       req;
    logic [POS_BITS-1:0]        row;
    logic [POS_BITS-1:0]        col;
    logic [PIXEL_BITS-1:0]      pixel;
    logic [MASK_BITS-1:0]       mask;
    logic [NDIM_BITS-1:0]       nw;
    logic [NDIM_BITS-1:0]       nh;
    logic signed [OFF_BITS-1:0] off_r;
    logic signed [OFF_BITS-1:0] off_c;
  } q_item_t;

  // Source size register values of zero read as one, above MAX_DIM as MAX_DIM.
  function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [SIZE_BITS-1:0] d);
    logic [SIZE_BITS-1:0] r;
    if (d == '0) begin
      r = SIZE_BITS'(1);
    end else if (d > SIZE_BITS'(MAX_DIM)) begin
      r = SIZE_BITS'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [DIM_OUT_BITS-1:0] sat_dim(input logic [NDIM_BITS-1:0] d);
    logic [DIM_OUT_BITS-1:0] r;
    if (d > NDIM_BITS'(DIM_OUT_MAX)) begin
      r = DIM_OUT_MAX;
    end else begin
      r = d[DIM_OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/image_rotate_nearest_masked.sv -----
`timescale 1ns / 1ps

// Nearest-neighbor image rotation by inverse mapping, with a mask plane.
// A command transaction is taken on the clock edge where start is high and
// busy is low. A write transaction (in_req_type 0) stores in_pixel_in and
// in_mask_in at row in_pos_row, column in_pos_col of a 64 x 64 source image;
// writes outside that image are dropped and produce no result. A read
// transaction (in_req_type 1) names a destination point, which is mapped back
// through the inverse rotation given by the sine and cosine registers.
// Each read produces exactly one result transaction: out_valid is high for
// one cycle with the pixel, mask, inside flag and rotated size, after the
// front end, queue and back pipeline. The receiver cannot hold results off.
// Throughput is one transaction per clock: the front end computes the
// rotated size and corner offset, a four-entry queue hands items to the back
// pipeline (offset, multiply, truncate, store access, result register), and
// the single store port serves one write or one read each cycle. Busy only
// rises if the queue could overflow, which the free-running back end avoids.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must only be made while no read is in flight. Reset sets sine 0, cosine
// 1.0, a 64 x 64 source and no mask; the image store itself is not cleared.
module image_rotate_nearest_masked (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_req_type,
  input  logic [irnm_pkg::POS_BITS-1:0]        in_pos_row,
  input  logic [irnm_pkg::POS_BITS-1:0]        in_pos_col,
  input  logic [irnm_pkg::PIXEL_BITS-1:0]      in_pixel_in,
  input  logic [irnm_pkg::MASK_BITS-1:0]       in_mask_in,
  output logic                                 out_valid,
  output logic [irnm_pkg::PIXEL_BITS-1:0]      out_pixel_out,
  output logic [irnm_pkg::MASK_BITS-1:0]       out_mask_out,
  output logic                                 out_from_source,
  output logic [irnm_pkg::DIM_OUT_BITS-1:0]    out_rotated_width,
  output logic [irnm_pkg::DIM_OUT_BITS-1:0]    out_rotated_height,
  input  logic                                 cfg_we,
  input  logic [irnm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [irnm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  irnm_pkg::cfg_t                         cfg_r;
  logic                                   push, pop;
  irnm_pkg::q_item_t                      push_item, pop_item;
  logic [irnm_pkg::QCNT_BITS-1:0]         q_count;

  // Configuration registers. Sizes keep their low seven bits and are
  // clamped to the valid range where they are used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sine         <= '0;
      cfg_r.cosine       <= irnm_pkg::TRIG_BITS'(1 << irnm_pkg::FRAC_BITS);
      cfg_r.width        <= irnm_pkg::SIZE_BITS'(irnm_pkg::MAX_DIM);
      cfg_r.height       <= irnm_pkg::SIZE_BITS'(irnm_pkg::MAX_DIM);
      cfg_r.mask_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (irnm_pkg::cfg_idx_t'(cfg_index))
        irnm_pkg::CFG_SINE:   cfg_r.sine   <= cfg_wdata[irnm_pkg::TRIG_BITS-1:0];
        irnm_pkg::CFG_COSINE: cfg_r.cosine <= cfg_wdata[irnm_pkg::TRIG_BITS-1:0];
        irnm_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_wdata[irnm_pkg::SIZE_BITS-1:0];
        irnm_pkg::CFG_HEIGHT: cfg_r.height <= cfg_wdata[irnm_pkg::SIZE_BITS-1:0];
        irnm_pkg::CFG_MASK:   cfg_r.mask_present <= cfg_wdata[0];
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // Front end: takes the transaction and works out the rotated geometry.
  irnm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_pos_row  (in_pos_row),
    .in_pos_col  (in_pos_col),
    .in_pixel_in (in_pixel_in),
    .in_mask_in  (in_mask_in),
    .cfg         (cfg_r),
    .q_count     (q_count),
    .push        (push),
    .push_item   (push_item)
  );

  // Short queue that decouples the front end from the mapping pipeline.
  irnm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .count     (q_count)
  );

  // Back end: inverse mapping, image store and result register.
  irnm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_vld             (pop),
    .in_item            (pop_item),
    .out_valid          (out_valid),
    .out_pixel_out      (out_pixel_out),
    .out_mask_out       (out_mask_out),
    .out_from_source    (out_from_source),
    .out_rotated_width  (out_rotated_width),
    .out_rotated_height (out_rotated_height)
  );

endmodule

// ----- src/irnm_front.sv -----
`timescale 1ns / 1ps

module irnm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [irnm_pkg::POS_BITS-1:0]       in_pos_row,
  input  logic [irnm_pkg::POS_BITS-1:0]       in_pos_col,
  input  logic [irnm_pkg::PIXEL_BITS-1:0]     in_pixel_in,
  input  logic [irnm_pkg::MASK_BITS-1:0]      in_mask_in,
  input  irnm_pkg::cfg_t                      cfg,
  input  logic [irnm_pkg::QCNT_BITS-1:0]      q_count,
  output logic                                push,
  output irnm_pkg::q_item_t                   push_item
);

  localparam int PEND_BITS = irnm_pkg::QCNT_BITS + 1;
  localparam int PSUM_BITS = irnm_pkg::PROD_BITS + 1;

  logic                               accept;
  logic [PEND_BITS-1:0]               pending;
  logic [irnm_pkg::SIZE_BITS-1:0]     w_cl, h_cl;
  logic [irnm_pkg::TRIG_BITS-1:0]     abs_s, abs_c;
  irnm_pkg::quad_t                    quad;

  logic                               f1_vld_r;
  irnm_pkg::req_t                     f1_req_r;
  logic [irnm_pkg::POS_BITS-1:0]      f1_row_r, f1_col_r;
  logic [irnm_pkg::PIXEL_BITS-1:0]    f1_pix_r;
  logic [irnm_pkg::MASK_BITS-1:0]     f1_msk_r;
  irnm_pkg::quad_t                    f1_quad_r;
  logic [irnm_pkg::TRIG_BITS-1:0]     f1_as_r, f1_ac_r;
  logic [irnm_pkg::PROD_BITS-1:0]     f1_was_r, f1_wac_r, f1_has_r, f1_hac_r;

  logic [PSUM_BITS-1:0]               sum_w, sum_h;
  logic [irnm_pkg::NDIM_BITS-1:0]     nw_full, nh_full;
  irnm_pkg::q_item_t                  f2_item_nxt, f2_item_r;
  logic                               f2_vld_r;

  // Items still upstream of the queue count against its free space.
  assign pending = PEND_BITS'(q_count) + PEND_BITS'(f1_vld_r) + PEND_BITS'(f2_vld_r);
  assign busy    = (pending >= PEND_BITS'(irnm_pkg::QUEUE_DEPTH));
  assign accept  = start && !busy;

  assign w_cl  = irnm_pkg::clamp_dim(cfg.width);
  assign h_cl  = irnm_pkg::clamp_dim(cfg.height);
  assign abs_s = cfg.sine[irnm_pkg::TRIG_BITS-1] ? (~cfg.sine + 1'b1) : cfg.sine;
  assign abs_c = cfg.cosine[irnm_pkg::TRIG_BITS-1] ? (~cfg.cosine + 1'b1) : cfg.cosine;

  always_comb begin
    unique case ({cfg.sine[irnm_pkg::TRIG_BITS-1], cfg.cosine[irnm_pkg::TRIG_BITS-1]})
      2'b00:   quad = irnm_pkg::QUAD_FIRST;
      2'b01:   quad = irnm_pkg::QUAD_SECOND;
      2'b11:   quad = irnm_pkg::QUAD_THIRD;
      default: quad = irnm_pkg::QUAD_FOURTH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    f1_req_r  <= irnm_pkg::req_t'(in_req_type);
    f1_row_r  <= in_pos_row;
    f1_col_r  <= in_pos_col;
    f1_pix_r  <= in_pixel_in;
    f1_msk_r  <= in_mask_in;
    f1_quad_r <= quad;
    f1_as_r   <= abs_s;
    f1_ac_r   <= abs_c;
    f1_was_r  <= irnm_pkg::PROD_BITS'(w_cl) * irnm_pkg::PROD_BITS'(abs_s);
    f1_wac_r  <= irnm_pkg::PROD_BITS'(w_cl) * irnm_pkg::PROD_BITS'(abs_c);
    f1_has_r  <= irnm_pkg::PROD_BITS'(h_cl) * irnm_pkg::PROD_BITS'(abs_s);
    f1_hac_r  <= irnm_pkg::PROD_BITS'(h_cl) * irnm_pkg::PROD_BITS'(abs_c);
  end

  // Whole-pixel rotated size; top-left offset with FRAC_BITS fraction bits.
  assign sum_w   = PSUM_BITS'(f1_has_r) + PSUM_BITS'(f1_wac_r);
  assign sum_h   = PSUM_BITS'(f1_was_r) + PSUM_BITS'(f1_hac_r);
  assign nw_full = sum_w[irnm_pkg::FRAC_BITS +: irnm_pkg::NDIM_BITS];
  assign nh_full = sum_h[irnm_pkg::FRAC_BITS +: irnm_pkg::NDIM_BITS];

  always_comb begin
    f2_item_nxt.req   = f1_req_r;
    f2_item_nxt.row   = f1_row_r;
    f2_item_nxt.col   = f1_col_r;
    f2_item_nxt.pixel = f1_pix_r;
    f2_item_nxt.mask  = f1_msk_r;
    f2_item_nxt.nw    = nw_full;
    f2_item_nxt.nh    = nh_full;
    unique case (f1_quad_r)
      irnm_pkg::QUAD_FIRST: begin
        f2_item_nxt.off_r = irnm_pkg::OFF_BITS'(f1_was_r) - irnm_pkg::OFF_BITS'(f1_as_r);
        f2_item_nxt.off_c = '0;
      end
      irnm_pkg::QUAD_SECOND: begin
        f2_item_nxt.off_r = irnm_pkg::OFF_BITS'(
          (irnm_pkg::OFF_BITS'(nh_full) - irnm_pkg::OFF_BITS'(1)) << irnm_pkg::FRAC_BITS);
        f2_item_nxt.off_c = irnm_pkg::OFF_BITS'(f1_wac_r) - irnm_pkg::OFF_BITS'(f1_ac_r);
      end
      irnm_pkg::QUAD_THIRD: begin
        f2_item_nxt.off_r = irnm_pkg::OFF_BITS'(f1_hac_r) - irnm_pkg::OFF_BITS'(f1_ac_r);
        f2_item_nxt.off_c = irnm_pkg::OFF_BITS'(
          (irnm_pkg::OFF_BITS'(nw_full) - irnm_pkg::OFF_BITS'(1)) << irnm_pkg::FRAC_BITS);
      end
      default: begin
        f2_item_nxt.off_r = '0;
        f2_item_nxt.off_c = irnm_pkg::OFF_BITS'(f1_has_r) - irnm_pkg::OFF_BITS'(f1_as_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_item_r <= f2_item_nxt;
  end

  assign push      = f2_vld_r;
  assign push_item = f2_item_r;

endmodule

// ----- src/irnm_queue.sv -----
`timescale 1ns / 1ps

module irnm_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  irnm_pkg::q_item_t              push_item,
  output logic                           pop,
  output irnm_pkg::q_item_t              pop_item,
  output logic [irnm_pkg::QCNT_BITS-1:0] count
);

  irnm_pkg::q_item_t                 slot_r [irnm_pkg::QUEUE_DEPTH];
  logic [irnm_pkg::QPTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [irnm_pkg::QCNT_BITS-1:0]    count_r, count_nxt;

  // The back end never stalls, so an entry leaves as soon as one is present.
  assign pop      = (count_r != '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/irnm_back.sv -----
`timescale 1ns / 1ps

module irnm_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  irnm_pkg::cfg_t                       cfg,
  input  logic                                 in_vld,
  input  irnm_pkg::q_item_t                    in_item,
  output logic                                 out_valid,
  output logic [irnm_pkg::PIXEL_BITS-1:0]      out_pixel_out,
  output logic [irnm_pkg::MASK_BITS-1:0]       out_mask_out,
  output logic                                 out_from_source,
  output logic [irnm_pkg::DIM_OUT_BITS-1:0]    out_rotated_width,
  output logic [irnm_pkg::DIM_OUT_BITS-1:0]    out_rotated_height
);

  localparam int WORD_BITS = irnm_pkg::PIXEL_BITS + irnm_pkg::MASK_BITS;

  logic signed [irnm_pkg::TRIG_BITS-1:0] sin_s, cos_s;
  logic [irnm_pkg::SIZE_BITS-1:0]        w_cl, h_cl;

  // Stage 1: offsets applied.
  logic                                  b1_vld_r;
  irnm_pkg::req_t                        b1_req_r;
  logic [irnm_pkg::POS_BITS-1:0]         b1_row_r, b1_col_r;
  logic [WORD_BITS-1:0]                  b1_data_r;
  logic signed [irnm_pkg::OFF_BITS-1:0]  b1_r2_r, b1_c2_r;
  logic                                  b1_inwin_r;
  logic [irnm_pkg::DIM_OUT_BITS-1:0]     b1_nw_r, b1_nh_r;

  // Stage 2: products.
  logic                                  b2_vld_r;
  irnm_pkg::req_t                        b2_req_r;
  logic [irnm_pkg::POS_BITS-1:0]         b2_row_r, b2_col_r;
  logic [WORD_BITS-1:0]                  b2_data_r;
  logic signed [irnm_pkg::MUL_BITS-1:0]  b2_prc_r, b2_pcs_r, b2_pcc_r, b2_prs_r;
  logic                                  b2_inwin_r;
  logic [irnm_pkg::DIM_OUT_BITS-1:0]     b2_nw_r, b2_nh_r;

  // Stage 3: source coordinate and store access decision.
  logic signed [irnm_pkg::SUM_BITS-1:0]  sum_r, sum_c;
  logic [irnm_pkg::SUM_BITS-1:0]         tr_r, tr_c;
  logic [irnm_pkg::MAP_BITS-1:0]         map_r, map_c;
  logic                                  hit;
  logic                                  wr_ok;
  logic                                  b3_vld_r;
  logic                                  b3_we_r;
  logic [irnm_pkg::ADDR_BITS-1:0]        b3_addr_r;
  logic [WORD_BITS-1:0]                  b3_data_r;
  logic                                  b3_inside_r;
  logic [irnm_pkg::DIM_OUT_BITS-1:0]     b3_nw_r, b3_nh_r;

  // Stage 4: store read.
  logic [WORD_BITS-1:0]                  store_mem [irnm_pkg::STORE_DEPTH];
  logic [WORD_BITS-1:0]                  b4_rd_r;
  logic                                  b4_vld_r;
  logic                                  b4_inside_r;
  logic [irnm_pkg::DIM_OUT_BITS-1:0]     b4_nw_r, b4_nh_r;
  logic [irnm_pkg::MASK_BITS-1:0]        rd_mask;

  // Stage 5: result register.
  logic                                  out_valid_r;
  logic [irnm_pkg::PIXEL_BITS-1:0]       out_pixel_r, out_pixel_nxt;
  logic [irnm_pkg::MASK_BITS-1:0]        out_mask_r, out_mask_nxt;
  logic                                  out_src_r;
  logic [irnm_pkg::DIM_OUT_BITS-1:0]     out_nw_r, out_nh_r;

  assign sin_s = cfg.sine;
  assign cos_s = cfg.cosine;
  assign w_cl  = irnm_pkg::clamp_dim(cfg.width);
  assign h_cl  = irnm_pkg::clamp_dim(cfg.height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      b3_vld_r    <= 1'b0;
      b3_we_r     <= 1'b0;
      b4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b1_vld_r    <= in_vld;
      b2_vld_r    <= b1_vld_r;
      b3_vld_r    <= b2_vld_r && (b2_req_r == irnm_pkg::REQ_READ);
      b3_we_r     <= b2_vld_r && (b2_req_r == irnm_pkg::REQ_WRITE) && wr_ok;
      b4_vld_r    <= b3_vld_r;
      out_valid_r <= b4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b1_req_r   <= in_item.req;
    b1_row_r   <= in_item.row;
    b1_col_r   <= in_item.col;
    b1_data_r  <= {in_item.pixel, in_item.mask};
    b1_r2_r    <= $signed(irnm_pkg::OFF_BITS'(in_item.row) << irnm_pkg::FRAC_BITS)
                  - in_item.off_r;
    b1_c2_r    <= $signed(irnm_pkg::OFF_BITS'(in_item.col) << irnm_pkg::FRAC_BITS)
                  - in_item.off_c;
    b1_inwin_r <= (irnm_pkg::NDIM_BITS'(in_item.row) < in_item.nh)
               && (irnm_pkg::NDIM_BITS'(in_item.col) < in_item.nw);
    b1_nw_r    <= irnm_pkg::sat_dim(in_item.nw);
    b1_nh_r    <= irnm_pkg::sat_dim(in_item.nh);
  end

  always_ff @(posedge clk) begin
    b2_req_r   <= b1_req_r;
    b2_row_r   <= b1_row_r;
    b2_col_r   <= b1_col_r;
    b2_data_r  <= b1_data_r;
    b2_prc_r   <= irnm_pkg::MUL_BITS'(b1_r2_r) * irnm_pkg::MUL_BITS'(cos_s);
    b2_pcs_r   <= irnm_pkg::MUL_BITS'(b1_c2_r) * irnm_pkg::MUL_BITS'(sin_s);
    b2_pcc_r   <= irnm_pkg::MUL_BITS'(b1_c2_r) * irnm_pkg::MUL_BITS'(cos_s);
    b2_prs_r   <= irnm_pkg::MUL_BITS'(b1_r2_r) * irnm_pkg::MUL_BITS'(sin_s);
    b2_inwin_r <= b1_inwin_r;
    b2_nw_r    <= b1_nw_r;
    b2_nh_r    <= b1_nh_r;
  end

  // Inverse rotation, truncated toward zero: negative sums get a bias of
  // one less than the divisor before the shift.
  assign sum_r = irnm_pkg::SUM_BITS'(b2_prc_r) + irnm_pkg::SUM_BITS'(b2_pcs_r);
  assign sum_c = irnm_pkg::SUM_BITS'(b2_pcc_r) - irnm_pkg::SUM_BITS'(b2_prs_r);
  assign tr_r  = sum_r[irnm_pkg::SUM_BITS-1] ? (sum_r + irnm_pkg::TRUNC_BIAS) : sum_r;
  assign tr_c  = sum_c[irnm_pkg::SUM_BITS-1] ? (sum_c + irnm_pkg::TRUNC_BIAS) : sum_c;
  assign map_r = tr_r[irnm_pkg::SUM_BITS-1 -: irnm_pkg::MAP_BITS];
  assign map_c = tr_c[irnm_pkg::SUM_BITS-1 -: irnm_pkg::MAP_BITS];

  assign hit = b2_inwin_r
            && !map_r[irnm_pkg::MAP_BITS-1]
            && !map_c[irnm_pkg::MAP_BITS-1]
            && (map_r[irnm_pkg::MAP_BITS-2:0] < (irnm_pkg::MAP_BITS-1)'(h_cl))
            && (map_c[irnm_pkg::MAP_BITS-2:0] < (irnm_pkg::MAP_BITS-1)'(w_cl));

  assign wr_ok = (b2_row_r < irnm_pkg::POS_BITS'(irnm_pkg::MAX_DIM))
              && (b2_col_r < irnm_pkg::POS_BITS'(irnm_pkg::MAX_DIM));

  always_ff @(posedge clk) begin
    if (b2_req_r == irnm_pkg::REQ_WRITE) begin
      b3_addr_r <= {b2_row_r[irnm_pkg::DIM_BITS-1:0], b2_col_r[irnm_pkg::DIM_BITS-1:0]};
    end else begin
      b3_addr_r <= {map_r[irnm_pkg::DIM_BITS-1:0], map_c[irnm_pkg::DIM_BITS-1:0]};
    end
    b3_data_r   <= b2_data_r;
    b3_inside_r <= hit;
    b3_nw_r     <= b2_nw_r;
    b3_nh_r     <= b2_nh_r;
  end

  // One access per cycle: a write item writes, a read item reads.
  always_ff @(posedge clk) begin
    if (b3_we_r) begin
      store_mem[b3_addr_r] <= b3_data_r;
    end
    b4_rd_r <= store_mem[b3_addr_r];
  end

  always_ff @(posedge clk) begin
    b4_inside_r <= b3_inside_r;
    b4_nw_r     <= b3_nw_r;
    b4_nh_r     <= b3_nh_r;
  end

  assign rd_mask = b4_rd_r[irnm_pkg::MASK_BITS-1:0];

  always_comb begin
    if (b4_inside_r) begin
      out_pixel_nxt = b4_rd_r[WORD_BITS-1 -: irnm_pkg::PIXEL_BITS];
      out_mask_nxt  = cfg.mask_present ? rd_mask : '0;
    end else begin
      out_pixel_nxt = '0;
      out_mask_nxt  = irnm_pkg::BACKGROUND_MASK;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    out_mask_r  <= out_mask_nxt;
    out_src_r   <= b4_inside_r;
    out_nw_r    <= b4_nw_r;
    out_nh_r    <= b4_nh_r;
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_out      = out_pixel_r;
  assign out_mask_out       = out_mask_r;
  assign out_from_source    = out_src_r;
  assign out_rotated_width  = out_nw_r;
  assign out_rotated_height = out_nh_r;

endmodule

// ----- dv/tb_image_rotate_nearest_masked.sv -----
`timescale 1ns / 1ps

module tb_image_rotate_nearest_masked;
  import irnm_pkg::*;

  // Random transactions per configuration setting, and the number of settings.
  localparam int PHASE_ITEMS  = 92;
  localparam int NUM_SETTINGS = 12;
  // Cycles allowed for the last results to come out, and the quiet time
  // after them.
  localparam int DRAIN_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 12;

  // One expected result transaction of a read.
  typedef struct {
    logic [PIXEL_BITS-1:0]   pixel;
    logic [MASK_BITS-1:0]    mask;
    logic                    from_src;
    logic [DIM_OUT_BITS-1:0] width;
    logic [DIM_OUT_BITS-1:0] height;
  } rotated_pixel_t;

  // Scoreboard: keeps a private copy of the source image and the registers,
  // predicts the result of every accepted read and checks results in order.
  class rotation_board;
    logic [PIXEL_BITS-1:0] pixel_mem [STORE_DEPTH];
    logic [MASK_BITS-1:0]  mask_mem  [STORE_DEPTH];
    longint                sine;
    longint                cosine;
    int unsigned           width_reg;
    int unsigned           height_reg;
    bit                    has_mask;
    rotated_pixel_t        awaited_pixels [$];
    int                    mismatches;

    function new();
      sine       = 0;
      cosine     = 16384;
      width_reg  = 64;
      height_reg = 64;
      has_mask   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_SINE:   sine       = longint'($signed(val[TRIG_BITS-1:0]));
        CFG_COSINE: cosine     = longint'($signed(val[TRIG_BITS-1:0]));
        CFG_WIDTH:  width_reg  = val[SIZE_BITS-1:0];
        CFG_HEIGHT: height_reg = val[SIZE_BITS-1:0];
        CFG_MASK:   has_mask   = val[0];
        default: ;
      endcase
    endfunction

    // Effective source size and the unsaturated rotated size.
    function void dims(output longint w, output longint h,
                       output longint nw, output longint nh);
      longint as_v;
      longint ac_v;
      as_v = (sine < 0) ? -sine : sine;
      ac_v = (cosine < 0) ? -cosine : cosine;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_DIM) ? MAX_DIM : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_DIM) ? MAX_DIM : height_reg);
      nw = (h * as_v + w * ac_v) >>> FRAC_BITS;
      nh = (w * as_v + h * ac_v) >>> FRAC_BITS;
    endfunction

    function void note_request(req_t req, logic [POS_BITS-1:0] row,
                               logic [POS_BITS-1:0] col,
                               logic [PIXEL_BITS-1:0] pix,
                               logic [MASK_BITS-1:0] msk);
      longint         w, h, nw, nh, as_v, ac_v, one;
      longint         off_r, off_c, r2, c2, mr, mc, rr, cc;
      int             addr;
      quad_t          quad;
      rotated_pixel_t res;
      rr = row;
      cc = col;
      if (req == REQ_WRITE) begin
        // Writes outside the 64 x 64 store are dropped.
        if (rr < MAX_DIM && cc < MAX_DIM) begin
          addr = int'(rr * MAX_DIM + cc);
          pixel_mem[addr] = pix;
          mask_mem[addr]  = msk;
        end
        return;
      end
      one  = longint'(1) << FRAC_BITS;
      as_v = (sine < 0) ? -sine : sine;
      ac_v = (cosine < 0) ? -cosine : cosine;
      dims(w, h, nw, nh);
      if (sine >= 0 && cosine >= 0) begin
        quad = QUAD_FIRST;
      end else if (sine >= 0) begin
        quad = QUAD_SECOND;
      end else if (cosine < 0) begin
        quad = QUAD_THIRD;
      end else begin
        quad = QUAD_FOURTH;
      end
      case (quad)
        QUAD_FIRST: begin
          off_r = (w - 1) * as_v;
          off_c = 0;
        end
        QUAD_SECOND: begin
          off_r = (nh - 1) * one;
          off_c = (w - 1) * ac_v;
        end
        QUAD_THIRD: begin
          off_r = (h - 1) * ac_v;
          off_c = (nw - 1) * one;
        end
        default: begin
          off_r = 0;
          off_c = (h - 1) * as_v;
        end
      endcase
      res.pixel    = '0;
      res.mask     = BACKGROUND_MASK;
      res.from_src = 1'b0;
      if (rr < nh && cc < nw) begin
        r2 = rr * one - off_r;
        c2 = cc * one - off_c;
        // Signed division truncates toward zero, as the mapping requires.
        mr = (r2 * cosine + c2 * sine) / (longint'(1) << (2 * FRAC_BITS));
        mc = (c2 * cosine - r2 * sine) / (longint'(1) << (2 * FRAC_BITS));
        if (mr >= 0 && mr < h && mc >= 0 && mc < w) begin
          addr         = int'(mr * MAX_DIM + mc);
          res.from_src = 1'b1;
          res.pixel    = pixel_mem[addr];
          res.mask     = (has_mask && mask_mem[addr] != 0) ? mask_mem[addr] : '0;
        end
      end
      res.width  = (nw > DIM_OUT_MAX) ? DIM_OUT_MAX : DIM_OUT_BITS'(nw);
      res.height = (nh > DIM_OUT_MAX) ? DIM_OUT_MAX : DIM_OUT_BITS'(nh);
      awaited_pixels.push_back(res);
    endfunction

    function void check_result(logic [PIXEL_BITS-1:0] pixel,
                               logic [MASK_BITS-1:0] mask, logic from_src,
                               logic [DIM_OUT_BITS-1:0] width,
                               logic [DIM_OUT_BITS-1:0] height);
      rotated_pixel_t exp_px;
      if (awaited_pixels.size() == 0) begin
        $error("result transaction with no read waiting: pixel_out %h", pixel);
        mismatches++;
        return;
      end
      exp_px = awaited_pixels.pop_front();
      if (pixel !== exp_px.pixel) begin
        $error("pixel_out: expected %h, actual %h", exp_px.pixel, pixel);
        mismatches++;
      end
      if (mask !== exp_px.mask) begin
        $error("mask_out: expected %h, actual %h", exp_px.mask, mask);
        mismatches++;
      end
      if (from_src !== exp_px.from_src) begin
        $error("from_source: expected %b, actual %b", exp_px.from_src, from_src);
        mismatches++;
      end
      if (width !== exp_px.width) begin
        $error("rotated_width: expected %0d, actual %0d", exp_px.width, width);
        mismatches++;
      end
      if (height !== exp_px.height) begin
        $error("rotated_height: expected %0d, actual %0d", exp_px.height, height);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_req_type;
  logic [POS_BITS-1:0]       in_pos_row;
  logic [POS_BITS-1:0]       in_pos_col;
  logic [PIXEL_BITS-1:0]     in_pixel_in;
  logic [MASK_BITS-1:0]      in_mask_in;
  logic                      out_valid;
  logic [PIXEL_BITS-1:0]     out_pixel_out;
  logic [MASK_BITS-1:0]      out_mask_out;
  logic                      out_from_source;
  logic [DIM_OUT_BITS-1:0]   out_rotated_width;
  logic [DIM_OUT_BITS-1:0]   out_rotated_height;
  logic                      cfg_we;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  rotation_board board = new();

  // Percentage of cycles in which the sender holds back a transaction.
  int gap_pct;

  cfg_t settings [NUM_SETTINGS];

  always #5 clk = ~clk;

  image_rotate_nearest_masked u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_pos_row         (in_pos_row),
    .in_pos_col         (in_pos_col),
    .in_pixel_in        (in_pixel_in),
    .in_mask_in         (in_mask_in),
    .out_valid          (out_valid),
    .out_pixel_out      (out_pixel_out),
    .out_mask_out       (out_mask_out),
    .out_from_source    (out_from_source),
    .out_rotated_width  (out_rotated_width),
    .out_rotated_height (out_rotated_height),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Results are sampled at the rising edge that ends their single valid
  // cycle. The receiver has no way to stall the block, so every strobe is
  // checked right away against the oldest predicted read.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result(out_pixel_out, out_mask_out, out_from_source,
                         out_rotated_width, out_rotated_height);
    end
  end

  // Offers one command transaction at a falling edge and holds it until a
  // rising edge sees busy low. Start stays high afterwards; the next caller
  // either offers another transaction or lowers it at the next falling edge.
  task automatic send_item(req_t req, logic [POS_BITS-1:0] row,
                           logic [POS_BITS-1:0] col,
                           logic [PIXEL_BITS-1:0] pix,
                           logic [MASK_BITS-1:0] msk);
    @(negedge clk);
    start       = 1'b1;
    in_req_type = req;
    in_pos_row  = row;
    in_pos_col  = col;
    in_pixel_in = pix;
    in_mask_in  = msk;
    do @(posedge clk); while (busy);
    board.note_request(req, row, col, pix, msk);
  endtask

  task automatic pause(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Each cycle is idle with probability gap_pct, which makes the idle share
  // of the sender's cycles match that percentage.
  task automatic random_gap();
    while ($urandom_range(0, 99) < gap_pct) pause(1);
  endtask

  // Holds the sender off until every predicted read has come back, then lets
  // a few more cycles pass so that trailing writes leave the pipeline too.
  task automatic drain();
    int waited;
    waited = 0;
    pause(1);
    while (board.awaited_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    board.set_reg(idx, val);
  endtask

  // Registers are only touched once the block is idle.
  task automatic apply_setting(cfg_t st);
    drain();
    write_reg(CFG_SINE, CFG_DATA_BITS'(st.sine));
    write_reg(CFG_COSINE, CFG_DATA_BITS'(st.cosine));
    write_reg(CFG_WIDTH, CFG_DATA_BITS'(st.width));
    write_reg(CFG_HEIGHT, CFG_DATA_BITS'(st.height));
    write_reg(CFG_MASK, CFG_DATA_BITS'(st.mask_present));
  endtask

  // One random transaction. Reads mostly land inside the rotated image, with
  // a margin just past its edges; a few use any position at all. Writes stay
  // inside the store except for an occasional dropped one, which is not
  // counted since the block merely ignores it.
  task automatic random_item(output bit counted);
    req_t                  req;
    logic [POS_BITS-1:0]   row;
    logic [POS_BITS-1:0]   col;
    logic [PIXEL_BITS-1:0] pix;
    logic [MASK_BITS-1:0]  msk;
    longint                w, h, nw, nh, row_lim, col_lim;
    board.dims(w, h, nw, nh);
    counted = 1'b1;
    pix = $urandom();
    msk = ($urandom_range(0, 3) == 0) ? '0 : MASK_BITS'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 35) begin
      req = REQ_WRITE;
      row = POS_BITS'($urandom_range(0, MAX_DIM - 1));
      col = POS_BITS'($urandom_range(0, MAX_DIM - 1));
      if ($urandom_range(0, 19) == 0) begin
        row     = POS_BITS'($urandom_range(0, 127));
        col     = POS_BITS'($urandom_range(MAX_DIM, 127));
        counted = 1'b0;
      end
    end else begin
      req = REQ_READ;
      if ($urandom_range(0, 9) == 0) begin
        row = POS_BITS'($urandom_range(0, 127));
        col = POS_BITS'($urandom_range(0, 127));
      end else begin
        row_lim = (nh + 2 > 127) ? 127 : nh + 2;
        col_lim = (nw + 2 > 127) ? 127 : nw + 2;
        row = POS_BITS'($urandom_range(0, int'(row_lim)));
        col = POS_BITS'($urandom_range(0, int'(col_lim)));
      end
    end
    send_item(req, row, col, pix, msk);
    random_gap();
  endtask

  initial begin
    cfg_t st;
    int   p, n, r, c, v;
    bit   counted;

    // Every input is known from time zero.
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_WRITE;
    in_pos_row  = '0;
    in_pos_col  = '0;
    in_pixel_in = '0;
    in_mask_in  = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SINE;
    cfg_wdata   = '0;
    gap_pct     = 0;

    // Settings cover every quadrant and its boundaries, the size clamps,
    // rotated sizes beyond the output range, an empty rotated image and
    // the masked and unmasked cases. The last one is drawn at random.
    settings[0]  = '{sine: 16'sd0, cosine: 16'sd16384, width: 7'd64,
                     height: 7'd64, mask_present: 1'b1};
    settings[1]  = '{sine: 16'sd16384, cosine: 16'sd0, width: 7'd40,
                     height: 7'd23, mask_present: 1'b1};
    settings[2]  = '{sine: 16'sd8192, cosine: 16'sd14189, width: 7'd64,
                     height: 7'd64, mask_present: 1'b0};
    settings[3]  = '{sine: 16'sd8192, cosine: -16'sd14189, width: 7'd17,
                     height: 7'd50, mask_present: 1'b1};
    settings[4]  = '{sine: -16'sd11585, cosine: -16'sd11585, width: 7'd64,
                     height: 7'd33, mask_present: 1'b1};
    settings[5]  = '{sine: -16'sd14189, cosine: 16'sd8192, width: 7'd1,
                     height: 7'd64, mask_present: 1'b1};
    settings[6]  = '{sine: 16'sd0, cosine: -16'sd16384, width: 7'd0,
                     height: 7'd127, mask_present: 1'b1};
    settings[7]  = '{sine: -16'sd32768, cosine: -16'sd32768, width: 7'd64,
                     height: 7'd64, mask_present: 1'b1};
    settings[8]  = '{sine: 16'sd32767, cosine: 16'sd32767, width: 7'd100,
                     height: 7'd64, mask_present: 1'b0};
    settings[9]  = '{sine: 16'sd0, cosine: 16'sd0, width: 7'd5,
                     height: 7'd5, mask_present: 1'b1};
    settings[10] = '{sine: -16'sd16384, cosine: 16'sd0, width: 7'd64,
                     height: 7'd64, mask_present: 1'b1};
    settings[11] = settings[0];

    // Synchronous reset, held from time zero and released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apply_setting(settings[0]);

    // The store powers up undefined, so the whole source image is written
    // before the first read. About a quarter of the mask bytes are zero.
    for (r = 0; r < MAX_DIM; r++) begin
      for (c = 0; c < MAX_DIM; c++) begin
        send_item(REQ_WRITE, POS_BITS'(r), POS_BITS'(c), $urandom(),
                  ($urandom_range(0, 3) == 0) ? '0 : MASK_BITS'($urandom_range(0, 255)));
      end
    end

    // Directed transactions on the identity mapping: the corners of the
    // source, pixel and mask extremes, a zero mask, writes dropped for lying
    // outside the store, reads past the rotated image, and a read right
    // behind a write of the same pixel.
    send_item(REQ_WRITE, 7'd0, 7'd0, 32'hFFFF_FFFF, 8'h00);
    send_item(REQ_WRITE, 7'd63, 7'd63, 32'h0000_0000, 8'hFF);
    send_item(REQ_WRITE, 7'd0, 7'd63, 32'hA5A5_A5A5, 8'h01);
    send_item(REQ_WRITE, 7'd63, 7'd0, 32'h5A5A_5A5A, 8'h80);
    send_item(REQ_WRITE, 7'd64, 7'd5, 32'h1234_5678, 8'h77);
    send_item(REQ_WRITE, 7'd5, 7'd127, 32'h8765_4321, 8'h66);
    send_item(REQ_WRITE, 7'd127, 7'd127, 32'hDEAD_BEEF, 8'h55);
    send_item(REQ_READ, 7'd0, 7'd0, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd63, 7'd63, 32'hFFFF_FFFF, 8'hFF);
    send_item(REQ_READ, 7'd0, 7'd63, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd63, 7'd0, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd64, 7'd5, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd5, 7'd64, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd127, 7'd127, 32'h0, 8'h0);
    send_item(REQ_WRITE, 7'd10, 7'd10, 32'h0F0F_0F0F, 8'h3C);
    send_item(REQ_READ, 7'd10, 7'd10, 32'h0, 8'h0);
    send_item(REQ_WRITE, 7'd10, 7'd10, 32'hF0F0_F0F0, 8'h00);
    send_item(REQ_READ, 7'd10, 7'd10, 32'h0, 8'h0);
    send_item(REQ_READ, 7'd5, 7'd5, 32'h0, 8'h0);

    // Random phases. The first third idles the sender in a quarter of the
    // cycles, the second third in most of them, the last third not at all.
    for (p = 0; p < NUM_SETTINGS; p++) begin
      st = settings[p];
      if (p == NUM_SETTINGS - 1) begin
        v = int'($urandom_range(0, 32768)) - 16384;
        st.sine = v[TRIG_BITS-1:0];
        v = int'($urandom_range(0, 32768)) - 16384;
        st.cosine = v[TRIG_BITS-1:0];
        st.width = SIZE_BITS'($urandom_range(1, MAX_DIM));
        st.height = SIZE_BITS'($urandom_range(1, MAX_DIM));
        st.mask_present = 1'($urandom_range(0, 1));
      end
      apply_setting(st);
      gap_pct = (p < 4) ? 25 : ((p < 8) ? 72 : 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) begin
          n++;
          // Now and then the sender stops until all reads have answered.
          if (n == PHASE_ITEMS / 2 && p % 4 == 1) drain();
        end
      end
    end

    drain();
    if (board.awaited_pixels.size() != 0) begin
      $error("%0d read results never arrived", board.awaited_pixels.size());
    end
    if (board.mismatches == 0 && board.awaited_pixels.size() == 0) begin
      $display("[image_rotate_nearest_masked] OK");
    end else begin
      $display("[image_rotate_nearest_masked] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the longest correct run.
  initial begin
    #2_000_000;
    $display("[image_rotate_nearest_masked] ERROR");
    $finish;
  end

endmodule
